### design/dfbp_pkg.sv
// ---------------------------------------------------------------------------
// dfbp_pkg
// Shared widths, codes and step tables for the Frechet bottleneck path core.
// ---------------------------------------------------------------------------
package dfbp_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_BITS_DEF = 16;

    localparam int MODE_W     = 2;
    localparam int IDX_W      = 5;
    localparam int FIELD_W    = 16;
    localparam int FRECHET_W  = 33;
    localparam int CFG_W      = 6;
    localparam int CELL_AW    = 2 * IDX_W;
    localparam int CELL_DEPTH = 1 << CELL_AW;
    localparam int HEAP_AW    = CELL_AW;
    localparam int COUNT_W    = HEAP_AW + 1;
    localparam int PATH_AW    = IDX_W + 1;
    localparam int MARK_W     = 3;
    localparam int RAW_W      = 32;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED      = 2'd3;

    localparam logic [1:0] DIR_NONE = 2'd3;

    localparam logic REG_FIRST_LEN  = 1'b0;
    localparam logic REG_SECOND_LEN = 1'b1;

    // step k: (+1,0), (+1,+1), (0,+1)
    function automatic logic step_di(input logic [1:0] k);
        logic v;
        unique case (k)
            2'd0:    v = 1'b1;
            2'd1:    v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic step_dj(input logic [1:0] k);
        logic v;
        unique case (k)
            2'd1:    v = 1'b1;
            2'd2:    v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

### design/dfbp_item_if.sv
// ---------------------------------------------------------------------------
// dfbp_item_if
// Input channel: point loads and search starts.
// ---------------------------------------------------------------------------
interface dfbp_item_if;
    logic                          valid;
    logic                          ready;
    logic [dfbp_pkg::MODE_W-1:0]   mode;
    logic [dfbp_pkg::IDX_W-1:0]    point_index;
    logic signed [dfbp_pkg::FIELD_W-1:0] x_coord;
    logic signed [dfbp_pkg::FIELD_W-1:0] y_coord;

    modport source (output valid, mode, point_index, x_coord, y_coord, input ready);
    modport sink   (input valid, mode, point_index, x_coord, y_coord, output ready);
endinterface

### design/dfbp_pair_if.sv
// ---------------------------------------------------------------------------
// dfbp_pair_if
// Output channel: one matched pair per beat.
// ---------------------------------------------------------------------------
interface dfbp_pair_if;
    logic                           valid;
    logic                           ready;
    logic [dfbp_pkg::IDX_W-1:0]     first_position;
    logic [dfbp_pkg::IDX_W-1:0]     second_position;
    logic [dfbp_pkg::FRECHET_W-1:0] frechet_squared;
    logic                           last_pair;

    modport source (output valid, first_position, second_position, frechet_squared,
                    last_pair, input ready);
    modport sink   (input valid, first_position, second_position, frechet_squared,
                    last_pair, output ready);
endinterface

### design/discrete_frechet_bottleneck_path_core.sv
// Point load: written to its point memory while idle; the core stays ready for the next item.
// Search: clear of all 1024 cell marks, then best-first pops and new-cell pushes, all
//   through the heap RAM, which has one write port and two read ports.
// Traceback: S_TB_RD, S_TB_CHK per path cell; per pair: S_EM_RD, S_EM_LD, S_EM_WAIT (held on sink stall).
// One item at a time; reset (synchronous, active low) empties the core and sets both
//   curve lengths to 1. Point memories hold garbage until loaded.
// ---------------------------------------------------------------------------
// discrete_frechet_bottleneck_path_core
// Best-first bottleneck search over the point-pair grid with heap in RAM.
// ---------------------------------------------------------------------------
module discrete_frechet_bottleneck_path_core #(
    parameter int MAX_POINTS = dfbp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dfbp_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dfbp_item_if.sink                   i_item,
    dfbp_pair_if.source                 o_pair,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfbp_pkg::APB_AW-1:0] paddr,
    input  logic [dfbp_pkg::APB_DW-1:0] pwdata,
    output logic [dfbp_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import dfbp_pkg::*;

    localparam int C          = COORD_BITS;
    localparam int DIST_W     = 2 * C + 1;
    localparam int ENT_W      = DIST_W + CELL_AW;
    localparam int HEAP_DEPTH = MAX_POINTS * MAX_POINTS;
    localparam int PATH_DEPTH = 2 * MAX_POINTS - 1;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_INIT_RD, S_DIFF, S_NB_RD, S_NB_CHK, S_D_MUL, S_D_SUM,
        S_UP, S_UP_CMP, S_POP_RD, S_POP_TOP, S_DN_RD, S_DN_CMP,
        S_TB_RD, S_TB_CHK, S_EM_RD, S_EM_LD, S_EM_WAIT
    } t_state;

    t_state                 r_state, n_state;
    logic [CELL_AW-1:0]     r_clr, n_clr;
    logic [CFG_W-1:0]       r_len_m, n_len_m, r_len_n, n_len_n;
    logic [IDX_W-1:0]       r_ci, n_ci, r_cj, n_cj, r_ni, n_ni, r_nj, n_nj;
    logic [1:0]             r_k, n_k;
    logic                   r_init, n_init;
    logic signed [C:0]      r_dx, n_dx, r_dy, n_dy;
    logic [DIST_W-1:0]      r_sqx, n_sqx, r_sqy, n_sqy, r_max, n_max;
    logic [ENT_W-1:0]       r_x, n_x;
    logic [HEAP_AW-1:0]     r_hole, n_hole;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic [PATH_AW-1:0]     r_cnt, n_cnt;
    logic                   r_ovalid, n_ovalid, r_olast, n_olast;
    logic [IDX_W-1:0]       r_ofirst, n_ofirst, r_osecond, n_osecond;
    logic [FRECHET_W-1:0]   r_ofrech, n_ofrech;

    // memory ports
    logic                   fp_we, sp_we;
    logic [IDX_W-1:0]       pt_raddr_f, pt_raddr_s;
    logic [2*C-1:0]         pt_wdata, fp_rdata, sp_rdata;
    logic                   mk_we;
    logic [CELL_AW-1:0]     mk_waddr, mk_raddr;
    logic [MARK_W-1:0]      mk_wdata, mk_rdata;
    logic                   hp_we;
    logic [HEAP_AW-1:0]     hp_waddr, hp_ra, hp_rb;
    logic [ENT_W-1:0]       hp_wdata, hp_rdata_a, hp_rdata_b;
    logic                   ph_we;
    logic [PATH_AW-1:0]     ph_waddr, ph_raddr;
    logic [CELL_AW-1:0]     ph_wdata, ph_rdata;

    logic [RAW_W-1:0]       w_xraw, w_yraw;
    logic [IDX_W-1:0]       w_m_last, w_n_last;
    logic [IDX_W:0]         w_ni, w_nj;
    logic signed [2*C+1:0]  w_px, w_py;
    logic [63:0]            w_max64;
    logic signed [C:0]      w_dx, w_dy;
    logic [COUNT_W-1:0]     w_lidx, w_ridx;
    logic [HEAP_AW-1:0]     w_parent;
    logic                   w_accept;

    assign w_xraw  = RAW_W'(i_item.x_coord) & RAW_W'({FIELD_W{1'b1}});
    assign w_yraw  = RAW_W'(i_item.y_coord) & RAW_W'({FIELD_W{1'b1}});
    assign pt_wdata = {w_xraw[C-1:0], w_yraw[C-1:0]};

    assign w_px    = r_dx * r_dx;
    assign w_py    = r_dy * r_dy;
    assign w_max64 = 64'(r_max);
    assign w_dx    = $signed({fp_rdata[2*C-1], fp_rdata[2*C-1:C]})
                   - $signed({sp_rdata[2*C-1], sp_rdata[2*C-1:C]});
    assign w_dy    = $signed({fp_rdata[C-1], fp_rdata[C-1:0]})
                   - $signed({sp_rdata[C-1], sp_rdata[C-1:0]});
    assign w_lidx  = {r_hole, 1'b1};
    assign w_ridx  = {r_hole, 1'b0} + COUNT_W'(2);
    assign w_parent = (r_hole - HEAP_AW'(1)) >> 1;
    assign w_accept = i_item.valid && i_item.ready;

    // a length of zero counts as one, above the maximum as the maximum
    always_comb begin
        if (r_len_m == '0)                      w_m_last = '0;
        else if (r_len_m > CFG_W'(MAX_POINTS))  w_m_last = IDX_W'(MAX_POINTS - 1);
        else                                    w_m_last = IDX_W'(r_len_m - CFG_W'(1));
        if (r_len_n == '0)                      w_n_last = '0;
        else if (r_len_n > CFG_W'(MAX_POINTS))  w_n_last = IDX_W'(MAX_POINTS - 1);
        else                                    w_n_last = IDX_W'(r_len_n - CFG_W'(1));
    end

    assign w_ni = {1'b0, r_ci} + (IDX_W+1)'(step_di(r_k));
    assign w_nj = {1'b0, r_cj} + (IDX_W+1)'(step_dj(r_k));

    always_comb begin
        logic [ENT_W-1:0] best;
        logic [1:0]       sel;
        logic [1:0]       dir;

        n_state = r_state;   n_clr = r_clr;       n_len_m = r_len_m;  n_len_n = r_len_n;
        n_ci = r_ci;         n_cj = r_cj;         n_ni = r_ni;        n_nj = r_nj;
        n_k = r_k;           n_init = r_init;     n_dx = r_dx;        n_dy = r_dy;
        n_sqx = r_sqx;       n_sqy = r_sqy;       n_max = r_max;      n_x = r_x;
        n_hole = r_hole;     n_count = r_count;   n_cnt = r_cnt;
        n_ovalid = r_ovalid; n_olast = r_olast;   n_ofirst = r_ofirst;
        n_osecond = r_osecond; n_ofrech = r_ofrech;

        fp_we = 1'b0; sp_we = 1'b0; pt_raddr_f = r_ni; pt_raddr_s = r_nj;
        mk_we = 1'b0; mk_waddr = {r_ni, r_nj}; mk_wdata = '0; mk_raddr = {r_ci, r_cj};
        hp_we = 1'b0; hp_waddr = r_hole; hp_wdata = r_x; hp_ra = '0; hp_rb = '0;
        ph_we = 1'b0; ph_waddr = r_cnt; ph_wdata = {r_ci, r_cj};
        ph_raddr = r_cnt - PATH_AW'(1);
        best = r_x; sel = 2'd0; dir = mk_rdata[1:0];

        if (psel && penable && pwrite) begin
            if (paddr[2] == REG_FIRST_LEN) n_len_m = pwdata[CFG_W-1:0];
            else                           n_len_n = pwdata[CFG_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.mode == MODE_LOAD_FIRST || i_item.mode == MODE_LOAD_SECOND) begin
                        if ({1'b0, i_item.point_index} < (IDX_W+1)'(MAX_POINTS)) begin
                            fp_we = (i_item.mode == MODE_LOAD_FIRST);
                            sp_we = (i_item.mode == MODE_LOAD_SECOND);
                        end
                    end else if (i_item.mode == MODE_START) begin
                        n_clr   = '0;
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                mk_we    = 1'b1;
                mk_waddr = r_clr;
                mk_wdata = '0;
                n_clr    = r_clr + CELL_AW'(1);
                if (r_clr == CELL_AW'(CELL_DEPTH - 1)) n_state = S_INIT_RD;
            end
            S_INIT_RD: begin
                pt_raddr_f = '0;
                pt_raddr_s = '0;
                mk_we      = 1'b1;
                mk_waddr   = '0;
                mk_wdata   = {1'b1, DIR_NONE};
                n_ni = '0; n_nj = '0; n_init = 1'b1; n_count = '0;
                n_state    = S_DIFF;
            end
            S_DIFF: begin
                n_dx = w_dx; n_dy = w_dy;
                n_state = S_D_MUL;
            end
            S_NB_RD: begin
                if (w_ni <= {1'b0, w_m_last} && w_nj <= {1'b0, w_n_last}) begin
                    pt_raddr_f = w_ni[IDX_W-1:0];
                    pt_raddr_s = w_nj[IDX_W-1:0];
                    mk_raddr   = {w_ni[IDX_W-1:0], w_nj[IDX_W-1:0]};
                    n_ni       = w_ni[IDX_W-1:0];
                    n_nj       = w_nj[IDX_W-1:0];
                    n_state    = S_NB_CHK;
                end else if (r_k == 2'd2) begin
                    n_state = S_POP_RD;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_NB_CHK: begin
                if (mk_rdata[MARK_W-1]) begin
                    if (r_k == 2'd2) n_state = S_POP_RD;
                    else begin
                        n_k = r_k + 2'd1;
                        n_state = S_NB_RD;
                    end
                end else begin
                    mk_we    = 1'b1;
                    mk_wdata = {1'b1, r_k};
                    n_dx = w_dx; n_dy = w_dy;
                    n_state  = S_D_MUL;
                end
            end
            S_D_MUL: begin
                n_sqx   = w_px[DIST_W-1:0];
                n_sqy   = w_py[DIST_W-1:0];
                n_state = S_D_SUM;
            end
            S_D_SUM: begin
                n_x     = {r_sqx + r_sqy, r_ni, r_nj};
                if (r_init) n_max = r_sqx + r_sqy;
                n_hole  = r_count[HEAP_AW-1:0];
                n_count = r_count + COUNT_W'(1);
                n_state = S_UP;
            end
            S_UP: begin
                if (r_hole == '0) begin
                    hp_we = 1'b1;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_POP_RD;
                    end else if (r_k == 2'd2) n_state = S_POP_RD;
                    else begin
                        n_k = r_k + 2'd1;
                        n_state = S_NB_RD;
                    end
                end else begin
                    hp_ra   = w_parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                hp_we = 1'b1;
                if (r_x < hp_rdata_a) begin
                    // parent moves down into the hole
                    hp_wdata = hp_rdata_a;
                    n_hole   = w_parent;
                    n_state  = S_UP;
                end else if (r_init) begin
                    n_init  = 1'b0;
                    n_state = S_POP_RD;
                end else if (r_k == 2'd2) n_state = S_POP_RD;
                else begin
                    n_k = r_k + 2'd1;
                    n_state = S_NB_RD;
                end
            end
            S_POP_RD: begin
                hp_ra   = '0;
                hp_rb   = HEAP_AW'(r_count - COUNT_W'(1));
                n_count = r_count - COUNT_W'(1);
                n_state = S_POP_TOP;
            end
            S_POP_TOP: begin
                if (hp_rdata_a[ENT_W-1:CELL_AW] > r_max) n_max = hp_rdata_a[ENT_W-1:CELL_AW];
                n_ci   = hp_rdata_a[CELL_AW-1:IDX_W];
                n_cj   = hp_rdata_a[IDX_W-1:0];
                n_k    = '0;
                n_x    = hp_rdata_b;
                n_hole = '0;
                if (hp_rdata_a[CELL_AW-1:IDX_W] == w_m_last && hp_rdata_a[IDX_W-1:0] == w_n_last)
                begin
                    n_cnt   = '0;
                    n_state = S_TB_RD;
                end else if (r_count == '0) n_state = S_NB_RD;
                else                        n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (w_lidx >= r_count) begin
                    hp_we   = 1'b1;
                    n_state = S_NB_RD;
                end else begin
                    hp_ra   = w_lidx[HEAP_AW-1:0];
                    hp_rb   = w_ridx[HEAP_AW-1:0];
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (w_lidx < r_count && hp_rdata_a < best) begin
                    best = hp_rdata_a;
                    sel  = 2'd1;
                end
                if (w_ridx < r_count && hp_rdata_b < best) begin
                    best = hp_rdata_b;
                    sel  = 2'd2;
                end
                hp_we    = 1'b1;
                hp_wdata = best;
                unique case (sel)
                    2'd1:    begin n_hole = w_lidx[HEAP_AW-1:0]; n_state = S_DN_RD; end
                    2'd2:    begin n_hole = w_ridx[HEAP_AW-1:0]; n_state = S_DN_RD; end
                    default: n_state = S_NB_RD;
                endcase
            end
            S_TB_RD: begin
                mk_raddr = {r_ci, r_cj};
                n_state  = S_TB_CHK;
            end
            S_TB_CHK: begin
                ph_we = 1'b1;
                n_cnt = r_cnt + PATH_AW'(1);
                if (dir == DIR_NONE || r_cnt == PATH_AW'(PATH_DEPTH - 1)) begin
                    n_state = S_EM_RD;
                end else begin
                    n_ci    = r_ci - IDX_W'(step_di(dir));
                    n_cj    = r_cj - IDX_W'(step_dj(dir));
                    n_state = S_TB_RD;
                end
            end
            S_EM_RD: begin
                n_state = S_EM_LD;
            end
            S_EM_LD: begin
                n_ofirst  = ph_rdata[CELL_AW-1:IDX_W];
                n_osecond = ph_rdata[IDX_W-1:0];
                n_ofrech  = w_max64[FRECHET_W-1:0];
                n_olast   = (r_cnt == PATH_AW'(1));
                n_ovalid  = 1'b1;
                n_state   = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (o_pair.ready) begin
                    n_ovalid = 1'b0;
                    n_cnt    = r_cnt - PATH_AW'(1);
                    n_state  = r_olast ? S_IDLE : S_EM_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len_m  <= CFG_W'(1);
            r_len_n  <= CFG_W'(1);
            r_ovalid <= 1'b0;
            r_init   <= 1'b0;
            r_count  <= '0;
            r_max    <= '0;
        end else begin
            r_state  <= n_state;
            r_len_m  <= n_len_m;
            r_len_n  <= n_len_n;
            r_ovalid <= n_ovalid;
            r_init   <= n_init;
            r_count  <= n_count;
            r_max    <= n_max;
        end
        r_clr <= n_clr;   r_ci <= n_ci;     r_cj <= n_cj;     r_ni <= n_ni;
        r_nj <= n_nj;     r_k <= n_k;       r_dx <= n_dx;     r_dy <= n_dy;
        r_sqx <= n_sqx;   r_sqy <= n_sqy;   r_x <= n_x;       r_hole <= n_hole;
        r_cnt <= n_cnt;   r_olast <= n_olast; r_ofirst <= n_ofirst;
        r_osecond <= n_osecond; r_ofrech <= n_ofrech;
    end

    assign i_item.ready           = (r_state == S_IDLE);
    assign o_pair.valid           = r_ovalid;
    assign o_pair.first_position  = r_ofirst;
    assign o_pair.second_position = r_osecond;
    assign o_pair.frechet_squared = r_ofrech;
    assign o_pair.last_pair       = r_olast;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FIRST_LEN) ? APB_DW'(r_len_m) : APB_DW'(r_len_n);

    dfbp_ram #(.WIDTH(2*C), .DEPTH(MAX_POINTS), .ADDR_W(IDX_W)) u_first_pts (
        .i_clk(i_clk), .i_we(fp_we), .i_waddr(i_item.point_index), .i_wdata(pt_wdata),
        .i_raddr_a(pt_raddr_f), .o_rdata_a(fp_rdata), .i_raddr_b(pt_raddr_f), .o_rdata_b()
    );

    dfbp_ram #(.WIDTH(2*C), .DEPTH(MAX_POINTS), .ADDR_W(IDX_W)) u_second_pts (
        .i_clk(i_clk), .i_we(sp_we), .i_waddr(i_item.point_index), .i_wdata(pt_wdata),
        .i_raddr_a(pt_raddr_s), .o_rdata_a(sp_rdata), .i_raddr_b(pt_raddr_s), .o_rdata_b()
    );

    dfbp_ram #(.WIDTH(MARK_W), .DEPTH(CELL_DEPTH), .ADDR_W(CELL_AW)) u_marks (
        .i_clk(i_clk), .i_we(mk_we), .i_waddr(mk_waddr), .i_wdata(mk_wdata),
        .i_raddr_a(mk_raddr), .o_rdata_a(mk_rdata), .i_raddr_b(mk_raddr), .o_rdata_b()
    );

    dfbp_ram #(.WIDTH(ENT_W), .DEPTH(HEAP_DEPTH), .ADDR_W(HEAP_AW)) u_heap (
        .i_clk(i_clk), .i_we(hp_we), .i_waddr(hp_waddr), .i_wdata(hp_wdata),
        .i_raddr_a(hp_ra), .o_rdata_a(hp_rdata_a), .i_raddr_b(hp_rb), .o_rdata_b(hp_rdata_b)
    );

    dfbp_ram #(.WIDTH(CELL_AW), .DEPTH(PATH_DEPTH), .ADDR_W(PATH_AW)) u_path (
        .i_clk(i_clk), .i_we(ph_we), .i_waddr(ph_waddr), .i_wdata(ph_wdata),
        .i_raddr_a(ph_raddr), .o_rdata_a(ph_rdata), .i_raddr_b(ph_raddr), .o_rdata_b()
    );
endmodule

### design/dfbp_ram.sv
// ---------------------------------------------------------------------------
// dfbp_ram
// Generic RAM, one write port, two registered read ports.
// ---------------------------------------------------------------------------
module dfbp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    output logic [WIDTH-1:0]  o_rdata_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

### design/dfbp_checker.sv
// ---------------------------------------------------------------------------
// dfbp_checker
// Port-level checks of the Frechet bottleneck path core, bound to the top.
// ---------------------------------------------------------------------------
module dfbp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_last,
    input logic [dfbp_pkg::FRECHET_W-1:0] i_out_frechet
);
    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_frechet))
        else $error("output beat dropped or changed while stalled");

    // no new item is taken while pairs are still going out
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a pair is pending");

    // after the final pair the core is free again
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> i_in_ready)
        else $error("core not ready after last pair");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");
endmodule

bind discrete_frechet_bottleneck_path_core dfbp_checker u_dfbp_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_item.ready),
    .i_out_valid(o_pair.valid),
    .i_out_ready(o_pair.ready),
    .i_out_last(o_pair.last_pair),
    .i_out_frechet(o_pair.frechet_squared)
);
